// ----- rtl/core/asts_pkg.sv -----
//------------------------------------------------------------------------------
// asts_pkg
// Shared types and constants for the arcball screen to sphere projection.
//------------------------------------------------------------------------------
package asts_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS = 14;
    localparam int SIZE_BITS = 13;
    localparam int RAD_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int Z_BITS = 15;

    localparam logic [1:0] REG_VIEW_WIDTH = 2'd0;
    localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BALL_RADIUS = 2'd2;

    localparam logic [SIZE_BITS-1:0] RST_VIEW_WIDTH = 13'd1024;
    localparam logic [SIZE_BITS-1:0] RST_VIEW_HEIGHT = 13'd768;
    localparam logic [RAD_BITS-1:0] RST_BALL_RADIUS = 16'd20480;

    typedef struct packed {
        logic [COORD_BITS-1:0] pointer_x;
        logic [COORD_BITS-1:0] pointer_y;
    } t_request;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sphere_x;
        logic signed [OUT_BITS-1:0] sphere_y;
        logic [Z_BITS-1:0] sphere_z;
        logic outside_ball;
    } t_result;

endpackage

// ----- rtl/core/asts_div_cell.sv -----
//------------------------------------------------------------------------------
// asts_div_cell
// One restoring-division step: a numerator bit shifted into the remainder, one quotient bit out.
//------------------------------------------------------------------------------
module asts_div_cell
    import asts_pkg::*;
#(
    parameter int RW = 32,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic          i_bit,
    output logic [RW-1:0] o_rem,
    output logic          o_q
);
    logic [RW:0] w_sh;
    logic [RW:0] w_dif;
    assign w_sh = {i_rem, i_bit};
    assign w_dif = w_sh - (RW+1)'(i_den);
    always_ff @(posedge i_clk) begin
        o_q <= ~w_dif[RW];
        o_rem <= w_dif[RW] ? w_sh[RW-1:0] : w_dif[RW-1:0];
    end
endmodule

// ----- rtl/core/asts_sqrt_cell.sv -----
//------------------------------------------------------------------------------
// asts_sqrt_cell
// One digit-by-digit square root step over a pair of radicand bits.
//------------------------------------------------------------------------------
module asts_sqrt_cell
    import asts_pkg::*;
#(
    parameter int W = 20
) (
    input  logic         i_clk,
    input  logic [W+1:0] i_rem,
    input  logic [W-1:0] i_root,
    input  logic [1:0]   i_pair,
    output logic [W+1:0] o_rem,
    output logic [W-1:0] o_root
);
    logic [W+3:0] w_sh;
    logic [W+3:0] w_dif;
    assign w_sh = {i_rem, i_pair};
    assign w_dif = w_sh - {2'b0, i_root, 2'b01};
    always_ff @(posedge i_clk) begin
        if (!w_dif[W+3]) begin
            o_rem <= w_dif[W+1:0];
            o_root <= {i_root[W-2:0], 1'b1};
        end else begin
            o_rem <= w_sh[W+1:0];
            o_root <= {i_root[W-2:0], 1'b0};
        end
    end
endmodule

// ----- rtl/core/arcball_screen_to_sphere_top.sv -----
// throughput: one request per cycle, busy is tied low
// pipeline: 36 division cells per axis, 18 square root cells, 31 normalize cells per axis and five registers
// synchronous active-low reset clears the valid chain and configuration registers
// the receiver cannot stall
//------------------------------------------------------------------------------
// arcball_screen_to_sphere_top
// Pointer position to unit arcball sphere vector, fully pipelined.
//------------------------------------------------------------------------------
module arcball_screen_to_sphere_top
    import asts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_request              i_request,
    output logic                  o_strobe,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    // widths
    localparam int F = FRAC_BITS;
    localparam int SL = F + 2;               // saturation magnitude bits
    localparam int QW = SL + 1;              // quotient magnitude width
    localparam int DEN_W = RAD_BITS + SIZE_BITS;
    localparam int MW = COORD_BITS + 1;
    localparam int NUM_W = MW + F + 9;       // numerator width
    localparam int RW1 = DEN_W + 1;
    localparam int D1 = NUM_W;               // stage 1 depth
    localparam int MAGW = 2 * QW + 1;
    localparam int SQW = (MAGW + 1) / 2;
    localparam int SQ_IN = 2 * SQW;
    localparam int NUM2 = QW + F;
    localparam int RW2 = SQW + 1;
    localparam int D2 = SQW;
    localparam int D3 = NUM2;
    localparam logic [QW-1:0] SAT = QW'(1) << SL;
    localparam logic [QW-1:0] ONEQ = QW'(1) << F;
    localparam logic [MAGW-1:0] ONE2 = MAGW'(1) << (2 * F);

    logic [SIZE_BITS-1:0] r_w, r_h;
    logic [RAD_BITS-1:0]  r_rad;

    assign pready = 1'b1;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RST_VIEW_WIDTH;
            r_h <= RST_VIEW_HEIGHT;
            r_rad <= RST_BALL_RADIUS;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_VIEW_WIDTH:  r_w <= pwdata[SIZE_BITS-1:0];
                REG_VIEW_HEIGHT: r_h <= pwdata[SIZE_BITS-1:0];
                REG_BALL_RADIUS: r_rad <= pwdata[RAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_VIEW_WIDTH:  prdata = 32'(r_w);
            REG_VIEW_HEIGHT: prdata = 32'(r_h);
            REG_BALL_RADIUS: prdata = 32'(r_rad);
            default:         prdata = 32'd0;
        endcase
    end

    // stage 0: centering and divisor products
    logic              r0_v;
    logic [MW-1:0]     r0_mx, r0_my;
    logic              r0_nx, r0_ny;
    logic [DEN_W-1:0]  r0_dx, r0_dy;
    logic signed [MW:0] w_dx, w_dy;
    assign w_dx = $signed({2'b0, i_request.pointer_x}) - $signed({2'b0, r_w[SIZE_BITS-1:1]});
    assign w_dy = $signed({2'b0, i_request.pointer_y}) - $signed({2'b0, r_h[SIZE_BITS-1:1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else r0_v <= start;
        r0_nx <= w_dx[MW];
        r0_ny <= w_dy[MW];
        r0_mx <= w_dx[MW] ? MW'(-w_dx) : MW'(w_dx);
        r0_my <= w_dy[MW] ? MW'(-w_dy) : MW'(w_dy);
        r0_dx <= DEN_W'(r_rad) * DEN_W'(r_w);
        r0_dy <= DEN_W'(r_rad) * DEN_W'(r_h);
    end

    // stage 1: division chains for both axes
    logic [RW1-1:0]   s1_rx [D1+1];
    logic [RW1-1:0]   s1_ry [D1+1];
    logic [NUM_W-1:0] s1_nx [D1+1];
    logic [NUM_W-1:0] s1_ny [D1+1];
    logic [D1-1:0]    s1_qx [D1+1];
    logic [D1-1:0]    s1_qy [D1+1];
    logic [DEN_W-1:0] s1_dx [D1+1];
    logic [DEN_W-1:0] s1_dy [D1+1];
    logic [1:0]       s1_sg [D1+1];
    logic [1:0]       s1_zr [D1+1];
    logic [D1:0]      s1_v;

    assign s1_rx[0] = '0;
    assign s1_ry[0] = '0;
    assign s1_nx[0] = {r0_mx, (F + 9)'(0)};
    assign s1_ny[0] = {r0_my, (F + 9)'(0)};
    assign s1_qx[0] = '0;
    assign s1_qy[0] = '0;
    assign s1_dx[0] = r0_dx;
    assign s1_dy[0] = r0_dy;
    assign s1_sg[0] = {r0_nx, r0_ny};
    assign s1_zr[0] = {r0_mx == '0, r0_my == '0};
    assign s1_v[0] = r0_v;

    for (genvar k = 0; k < D1; k++) begin : g_div1
        logic w_qx, w_qy;
        logic [D1-1:0] s1_qx_d, s1_qy_d;
        asts_div_cell #(.RW(RW1), .DW(DEN_W)) u_cx (
            .i_clk(i_clk), .i_rem(s1_rx[k]), .i_den(s1_dx[k]),
            .i_bit(s1_nx[k][NUM_W-1]), .o_rem(s1_rx[k+1]), .o_q(w_qx));
        asts_div_cell #(.RW(RW1), .DW(DEN_W)) u_cy (
            .i_clk(i_clk), .i_rem(s1_ry[k]), .i_den(s1_dy[k]),
            .i_bit(s1_ny[k][NUM_W-1]), .o_rem(s1_ry[k+1]), .o_q(w_qy));
        assign s1_qx[k+1] = {s1_qx_d[D1-2:0], w_qx};
        assign s1_qy[k+1] = {s1_qy_d[D1-2:0], w_qy};
        always_ff @(posedge i_clk) begin
            s1_qx_d <= s1_qx[k];
            s1_qy_d <= s1_qy[k];
            s1_nx[k+1] <= s1_nx[k] << 1;
            s1_ny[k+1] <= s1_ny[k] << 1;
            s1_dx[k+1] <= s1_dx[k];
            s1_dy[k+1] <= s1_dy[k];
            s1_sg[k+1] <= s1_sg[k];
            s1_zr[k+1] <= s1_zr[k];
            if (!i_rst_n) s1_v[k+1] <= 1'b0;
            else s1_v[k+1] <= s1_v[k];
        end
    end

    // stages 2 to 4: saturate, sign, square, sum and compare against one
    function automatic logic [QW-1:0] sat_q(input logic [D1-1:0] q, input logic [DEN_W-1:0] d,
                                            input logic z);
        logic [QW-1:0] r;
        r = (q > D1'(SAT) || d == '0) ? SAT : QW'(q);
        return z ? '0 : r;
    endfunction

    logic              r2_v;
    logic [QW-1:0]     r2_ax, r2_ay;
    logic [1:0]        r2_sg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= s1_v[D1];
        r2_ax <= sat_q(s1_qx[D1], s1_dx[D1], s1_zr[D1][1]);
        r2_ay <= sat_q(s1_qy[D1], s1_dy[D1], s1_zr[D1][0]);
        r2_sg <= {s1_sg[D1][1], ~s1_sg[D1][0]};
    end

    logic              r3_v;
    logic [QW-1:0]     r3_ax, r3_ay;
    logic [1:0]        r3_sg;
    logic [2*QW-1:0]   r3_px, r3_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_ax <= r2_ax;
        r3_ay <= r2_ay;
        r3_sg <= r2_sg;
        r3_px <= r2_ax * r2_ax;
        r3_py <= r2_ay * r2_ay;
    end

    logic              r4_v, r4_out;
    logic [QW-1:0]     r4_ax, r4_ay;
    logic [1:0]        r4_sg;
    logic [SQ_IN-1:0]  r4_rad;
    logic [MAGW-1:0]   w_mag;
    assign w_mag = MAGW'(r3_px) + MAGW'(r3_py);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r3_v;
        r4_ax <= r3_ax;
        r4_ay <= r3_ay;
        r4_sg <= r3_sg;
        r4_out <= w_mag > ONE2;
        r4_rad <= (w_mag > ONE2) ? SQ_IN'(w_mag) : SQ_IN'(ONE2 - w_mag);
    end

    // stage 5: square root chain
    logic [RW2:0]     s2_rem  [D2+1];
    logic [SQW-1:0]   s2_root [D2+1];
    logic [SQ_IN-1:0] s2_rad  [D2+1];
    logic [QW-1:0]    s2_ax [D2+1];
    logic [QW-1:0]    s2_ay [D2+1];
    logic [2:0]       s2_fl [D2+1];
    logic [D2:0]      s2_v;
    assign s2_rem[0] = '0;
    assign s2_root[0] = '0;
    assign s2_rad[0] = r4_rad;
    assign s2_ax[0] = r4_ax;
    assign s2_ay[0] = r4_ay;
    assign s2_fl[0] = {r4_out, r4_sg};
    assign s2_v[0] = r4_v;
    for (genvar k = 0; k < D2; k++) begin : g_sqrt
        asts_sqrt_cell #(.W(SQW)) u_c (
            .i_clk(i_clk), .i_rem(s2_rem[k]), .i_root(s2_root[k]),
            .i_pair(s2_rad[k][SQ_IN-1 -: 2]), .o_rem(s2_rem[k+1]), .o_root(s2_root[k+1]));
        always_ff @(posedge i_clk) begin
            s2_rad[k+1] <= s2_rad[k] << 2;
            s2_ax[k+1] <= s2_ax[k];
            s2_ay[k+1] <= s2_ay[k];
            s2_fl[k+1] <= s2_fl[k];
            if (!i_rst_n) s2_v[k+1] <= 1'b0;
            else s2_v[k+1] <= s2_v[k];
        end
    end

    // stage 6: normalize division chains
    logic [RW2-1:0]  s3_rx [D3+1];
    logic [RW2-1:0]  s3_ry [D3+1];
    logic [NUM2-1:0] s3_nx [D3+1];
    logic [NUM2-1:0] s3_ny [D3+1];
    logic [D3-1:0]   s3_qx [D3+1];
    logic [D3-1:0]   s3_qy [D3+1];
    logic [SQW-1:0]  s3_r  [D3+1];
    logic [2:0]      s3_fl [D3+1];
    logic [D3:0]     s3_v;
    assign s3_rx[0] = '0;
    assign s3_ry[0] = '0;
    assign s3_nx[0] = {s2_ax[D2], F'(0)};
    assign s3_ny[0] = {s2_ay[D2], F'(0)};
    assign s3_qx[0] = '0;
    assign s3_qy[0] = '0;
    assign s3_r[0] = s2_root[D2];
    assign s3_fl[0] = s2_fl[D2];
    assign s3_v[0] = s2_v[D2];
    for (genvar k = 0; k < D3; k++) begin : g_div2
        logic w_qx, w_qy;
        logic [D3-1:0] s3_qx_d, s3_qy_d;
        asts_div_cell #(.RW(RW2), .DW(SQW)) u_cx (
            .i_clk(i_clk), .i_rem(s3_rx[k]), .i_den(s3_r[k]),
            .i_bit(s3_nx[k][NUM2-1]), .o_rem(s3_rx[k+1]), .o_q(w_qx));
        asts_div_cell #(.RW(RW2), .DW(SQW)) u_cy (
            .i_clk(i_clk), .i_rem(s3_ry[k]), .i_den(s3_r[k]),
            .i_bit(s3_ny[k][NUM2-1]), .o_rem(s3_ry[k+1]), .o_q(w_qy));
        assign s3_qx[k+1] = {s3_qx_d[D3-2:0], w_qx};
        assign s3_qy[k+1] = {s3_qy_d[D3-2:0], w_qy};
        always_ff @(posedge i_clk) begin
            s3_qx_d <= s3_qx[k];
            s3_qy_d <= s3_qy[k];
            s3_nx[k+1] <= s3_nx[k] << 1;
            s3_ny[k+1] <= s3_ny[k] << 1;
            s3_r[k+1] <= s3_r[k];
            s3_fl[k+1] <= s3_fl[k];
            if (!i_rst_n) s3_v[k+1] <= 1'b0;
            else s3_v[k+1] <= s3_v[k];
        end
    end

    // keep pre-normalize values and root alongside
    logic [QW-1:0]  s3_ax [D3+1];
    logic [QW-1:0]  s3_ay [D3+1];
    assign s3_ax[0] = s2_ax[D2];
    assign s3_ay[0] = s2_ay[D2];
    for (genvar k = 0; k < D3; k++) begin : g_keep
        always_ff @(posedge i_clk) begin
            s3_ax[k+1] <= s3_ax[k];
            s3_ay[k+1] <= s3_ay[k];
        end
    end

    function automatic logic [OUT_BITS-1:0] sgn(input logic [QW-1:0] m, input logic n);
        logic [OUT_BITS-1:0] e;
        e = OUT_BITS'(m);
        return n ? -e : e;
    endfunction

    logic [QW-1:0] w_fx, w_fy;
    assign w_fx = (s3_qx[D3] > D3'(ONEQ)) ? ONEQ : QW'(s3_qx[D3]);
    assign w_fy = (s3_qy[D3] > D3'(ONEQ)) ? ONEQ : QW'(s3_qy[D3]);

    logic    r_strobe;
    t_result r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else r_strobe <= s3_v[D3];
        r_res.outside_ball <= s3_fl[D3][2];
        if (s3_fl[D3][2]) begin
            r_res.sphere_x <= sgn(w_fx, s3_fl[D3][1]);
            r_res.sphere_y <= sgn(w_fy, s3_fl[D3][0]);
            r_res.sphere_z <= '0;
        end else begin
            r_res.sphere_x <= sgn(s3_ax[D3], s3_fl[D3][1]);
            r_res.sphere_y <= sgn(s3_ay[D3], s3_fl[D3][0]);
            r_res.sphere_z <= Z_BITS'(s3_r[D3]);
        end
    end
    assign o_strobe = r_strobe;
    assign o_result = r_res;
endmodule
